// ----- design/krt_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// krt_pkg
// shared types, codes and constants of the keyed record table
// ---------------------------------------------------------------------------
package krt_pkg;

   localparam int WORD_W        = 64;
   localparam int WORDS         = 4;
   localparam int AGE_W         = 8;
   localparam int POS_W         = 5;
   localparam int KEY_BYTES     = 32;
   localparam int CAPACITY_DFLT = 16;

   typedef logic [WORDS-1:0][WORD_W-1:0] words_type;

   typedef struct packed {
      words_type        key;
      words_type        name;
      logic [AGE_W-1:0] age;
   } rec_type;

   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_REMOVE = 2'd1,
      FN_SEARCH = 2'd2,
      FN_LIST   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_ADDED      = 3'd0,
      ST_DUPLICATE  = 3'd1,
      ST_FULL       = 3'd2,
      ST_REMOVED    = 3'd3,
      ST_NOT_FOUND  = 3'd4,
      ST_FOUND      = 3'd5,
      ST_LIST_ENTRY = 3'd6,
      ST_LIST_EMPTY = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_LIST   = 2'd2,
      S_FINISH = 2'd3
   } state_type;

   // table moves handed from the sequencer to the cell chain
   typedef struct packed {
      logic rotate;
      logic compact;
      logic write;
   } chain_ctrl_type;

   // bytes of a key word that take part in matching
   function automatic logic [WORD_W-1:0] key_mask(input int w);
      int nbytes;
      nbytes = KEY_BYTES - 8 * w;
      if (nbytes >= 8) begin
         return '1;
      end else if (nbytes <= 0) begin
         return '0;
      end else begin
         return (WORD_W'(1) << (8 * nbytes)) - WORD_W'(1);
      end
   endfunction

endpackage
`default_nettype wire

// ----- design/krt_cell.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// krt_cell
// one record slot: takes its upper neighbour's record or a new record
// ---------------------------------------------------------------------------
module krt_cell (
   input  wire logic            clock,
   input  wire logic            shift_en,
   input  wire logic            load_en,
   input  wire krt_pkg::rec_type nbr_rec,
   input  wire krt_pkg::rec_type load_rec,
   output krt_pkg::rec_type      rec
);
   import krt_pkg::*;

   rec_type rec_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         rec_ff <= load_rec;
      end else if (shift_en) begin
         rec_ff <= nbr_rec;
      end
   end

   assign rec = rec_ff;

endmodule
`default_nettype wire

// ----- design/krt_chain.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// krt_chain
// row of record cells; rotates towards cell 0, compacts, or loads one slot
// ---------------------------------------------------------------------------
module krt_chain #(
   parameter int CAPACITY = krt_pkg::CAPACITY_DFLT,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic                  clock,
   input  wire krt_pkg::chain_ctrl_type ctrl,
   input  wire logic [CNT_W-1:0]      compact_from,
   input  wire logic [CNT_W-1:0]      write_at,
   input  wire krt_pkg::rec_type      write_rec,
   output krt_pkg::rec_type           head_rec
);
   import krt_pkg::*;

   rec_type cell_rec [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic    shift_en;
      logic    load_en;
      rec_type nbr;

      assign shift_en = ctrl.rotate ||
                        (ctrl.compact && (CNT_W'(i) >= compact_from));
      assign load_en  = ctrl.write && (CNT_W'(i) == write_at);
      // last cell closes the ring
      assign nbr      = (i == CAPACITY - 1) ? cell_rec[0] : cell_rec[(i + 1) % CAPACITY];

      krt_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .load_en  (load_en),
         .nbr_rec  (nbr),
         .load_rec (write_rec),
         .rec      (cell_rec[i])
      );
   end

   assign head_rec = cell_rec[0];

endmodule
`default_nettype wire

// ----- design/keyed_record_table_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// keyed_record_table_unit
// ordered keyed record table with add, remove, search and list commands
// ---------------------------------------------------------------------------
// usage
//   req_* carries one command transaction (func, key, name, age); rsp_* gives
//   result transactions, each with status, one-based position, the record
//   for found and list entry (zero otherwise) and last on the final one
//   records live in a ring of CAPACITY cells; cell 0 is the only one read
//   every command except list of an empty table walks the whole ring once,
//   one cell per cycle unless a list pauses on rsp_stall, so the table is
//   back in place when it ends; add, remove, search scan the ring, then a
//   finish step registers the result and the unit goes back to idle
//   list: one entry per cycle while the receiver takes them; list of an
//   empty table goes straight to the finish step, which returns list empty
//   req_stall is high while a command is in progress; the next request is
//   taken while the last result still waits in the output register
//   a stalled rsp transaction holds; list walking pauses on rsp_stall, the
//   finish cycle waits for the output register to free up
//   reset empties the table (record count to zero) and drops any result
// ---------------------------------------------------------------------------
module keyed_record_table_unit #(
   parameter int CAPACITY = krt_pkg::CAPACITY_DFLT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // command transactions
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_func,
   input  wire logic [krt_pkg::WORD_W-1:0]   req_key_w0,
   input  wire logic [krt_pkg::WORD_W-1:0]   req_key_w1,
   input  wire logic [krt_pkg::WORD_W-1:0]   req_key_w2,
   input  wire logic [krt_pkg::WORD_W-1:0]   req_key_w3,
   input  wire logic [krt_pkg::WORD_W-1:0]   req_name_w0,
   input  wire logic [krt_pkg::WORD_W-1:0]   req_name_w1,
   input  wire logic [krt_pkg::WORD_W-1:0]   req_name_w2,
   input  wire logic [krt_pkg::WORD_W-1:0]   req_name_w3,
   input  wire logic [krt_pkg::AGE_W-1:0]    req_age_in,
   // result transactions
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [krt_pkg::POS_W-1:0]         rsp_position,
   output logic [krt_pkg::WORD_W-1:0]        rsp_out_key_w0,
   output logic [krt_pkg::WORD_W-1:0]        rsp_out_key_w1,
   output logic [krt_pkg::WORD_W-1:0]        rsp_out_key_w2,
   output logic [krt_pkg::WORD_W-1:0]        rsp_out_key_w3,
   output logic [krt_pkg::WORD_W-1:0]        rsp_out_name_w0,
   output logic [krt_pkg::WORD_W-1:0]        rsp_out_name_w1,
   output logic [krt_pkg::WORD_W-1:0]        rsp_out_name_w2,
   output logic [krt_pkg::WORD_W-1:0]        rsp_out_name_w3,
   output logic [krt_pkg::AGE_W-1:0]         rsp_age_out,
   output logic                              rsp_last
);
   import krt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

   // sequencer state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] hit_ff, hit_in;

   // command held for the whole scan
   func_type         func_ff;
   words_type        key_ff;
   words_type        name_ff;
   logic [AGE_W-1:0] age_ff;
   rec_type          hit_rec_ff;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   rec_type          rsp_rec_ff, rsp_rec_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_take;
   logic             out_free;
   logic             scan_match;
   logic             list_adv;
   logic             list_emit;
   words_type        req_key_masked;
   rec_type          head_rec;
   rec_type          write_rec;
   chain_ctrl_type   ctrl;

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // bytes past the key length never take part in a match
   assign req_key_masked[0] = req_key_w0 & key_mask(0);
   assign req_key_masked[1] = req_key_w1 & key_mask(1);
   assign req_key_masked[2] = req_key_w2 & key_mask(2);
   assign req_key_masked[3] = req_key_w3 & key_mask(3);

   // first live record whose key matches
   assign scan_match = (step_ff < count_ff) && !found_ff && (head_rec.key == key_ff);

   // list: live slots wait for the output register, the rest of the ring spins freely
   assign list_emit = (step_ff < count_ff);
   assign list_adv  = !list_emit || out_free;

   assign write_rec.key  = key_ff;
   assign write_rec.name = name_ff;
   assign write_rec.age  = age_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (func_type'(req_func) == FN_LIST) begin
                  state_in = (count_ff == '0) ? S_FINISH : S_LIST;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (step_ff == LAST_STEP) begin
               state_in = S_FINISH;
            end
         end
         S_LIST: begin
            if (list_adv && (step_ff == LAST_STEP)) begin
               state_in = S_IDLE;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_stall     = 1'b1;
      ctrl          = '0;
      step_in       = step_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_take) begin
               step_in  = '0;
               found_in = 1'b0;
               hit_in   = '0;
            end
         end
         S_SCAN: begin
            ctrl.rotate = 1'b1;
            step_in     = step_ff + CNT_W'(1);
            if (scan_match) begin
               found_in = 1'b1;
               hit_in   = step_ff;
            end
         end
         S_LIST: begin
            if (list_adv) begin
               ctrl.rotate = 1'b1;
               step_in     = step_ff + CNT_W'(1);
               if (list_emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_LIST_ENTRY;
                  rsp_pos_in    = POS_W'(step_ff + CNT_W'(1));
                  rsp_rec_in    = head_rec;
                  rsp_last_in   = ((step_ff + CNT_W'(1)) == count_ff);
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_rec_in   = '0;
               rsp_pos_in   = '0;
               case (func_ff)
                  FN_ADD: begin
                     if (found_ff) begin
                        rsp_status_in = ST_DUPLICATE;
                        rsp_pos_in    = POS_W'(hit_ff + CNT_W'(1));
                     end else if (count_ff == FULL_CNT) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.write    = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = ST_ADDED;
                        rsp_pos_in    = POS_W'(count_ff + CNT_W'(1));
                     end
                  end
                  FN_REMOVE: begin
                     if (found_ff) begin
                        // later records slide down one slot
                        ctrl.compact  = 1'b1;
                        count_in      = count_ff - CNT_W'(1);
                        rsp_status_in = ST_REMOVED;
                        rsp_pos_in    = POS_W'(hit_ff + CNT_W'(1));
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  FN_SEARCH: begin
                     if (found_ff) begin
                        rsp_status_in = ST_FOUND;
                        rsp_pos_in    = POS_W'(hit_ff + CNT_W'(1));
                        rsp_rec_in    = hit_rec_ff;
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_LIST_EMPTY;
                  end
               endcase
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         hit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= func_type'(req_func);
         key_ff  <= req_key_masked;
         name_ff <= {req_name_w3, req_name_w2, req_name_w1, req_name_w0};
         age_ff  <= req_age_in;
      end
      if ((state_ff == S_SCAN) && scan_match) begin
         hit_rec_ff <= head_rec;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_last_ff   <= rsp_last_in;
   end

   krt_chain #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_chain (
      .clock        (clock),
      .ctrl         (ctrl),
      .compact_from (hit_ff),
      .write_at     (count_ff),
      .write_rec    (write_rec),
      .head_rec     (head_rec)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_out_key_w0  = rsp_rec_ff.key[0];
   assign rsp_out_key_w1  = rsp_rec_ff.key[1];
   assign rsp_out_key_w2  = rsp_rec_ff.key[2];
   assign rsp_out_key_w3  = rsp_rec_ff.key[3];
   assign rsp_out_name_w0 = rsp_rec_ff.name[0];
   assign rsp_out_name_w1 = rsp_rec_ff.name[1];
   assign rsp_out_name_w2 = rsp_rec_ff.name[2];
   assign rsp_out_name_w3 = rsp_rec_ff.name[3];
   assign rsp_age_out     = rsp_rec_ff.age;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire
